// ----- design/fixed_step_euler_integrator_top_macros.svh -----
// Assertion macros used by the checker of the integrator.
`ifndef FIXED_STEP_EULER_INTEGRATOR_TOP_MACROS_SVH
`define FIXED_STEP_EULER_INTEGRATOR_TOP_MACROS_SVH

// Property that must hold at every edge outside reset.
`define FSEI_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("integrator check failed");

// Consequent must hold at the clock edge after the antecedent.
`define FSEI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("integrator check failed");

`endif

// ----- design/fsei_pkg.sv -----
package fsei_pkg;

  localparam int VALUE_W   = 32;
  localparam int TIME_FRAC = 16;
  localparam int STEP_W    = 15;
  localparam int ACC_W     = 16;
  localparam int DAMP_W    = 18;
  localparam int COUNT_W   = 32;
  localparam int FSTEPS_W  = 15;
  localparam int ALPHA_W   = 16;
  localparam int FRAME_W   = 16;
  localparam int MULB_W    = 17;
  localparam int PROD_W    = VALUE_W + MULB_W + 1;

  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  // Frame time clamp: a quarter second.
  localparam logic [ACC_W-1:0]    FRAME_CAP       = ACC_W'(1 << (TIME_FRAC - 2));
  localparam logic [FSTEPS_W-1:0] MAX_FRAME_STEPS = FSTEPS_W'(16385);

  localparam logic CMD_ADVANCE = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef enum logic [2:0] {
    REG_STEP_TIME,
    REG_ACCEL_X,
    REG_ACCEL_Y,
    REG_DAMPING,
    REG_START_POS_X,
    REG_START_POS_Y,
    REG_START_VEL_X,
    REG_START_VEL_Y
  } reg_idx_e;

  typedef struct packed {
    logic               cmd;
    logic [FRAME_W-1:0] frame_time;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] pos_x;
    logic signed [VALUE_W-1:0] pos_y;
    logic signed [VALUE_W-1:0] vel_x;
    logic signed [VALUE_W-1:0] vel_y;
    logic signed [VALUE_W-1:0] prev_pos_x;
    logic signed [VALUE_W-1:0] prev_pos_y;
    logic signed [VALUE_W-1:0] prev_vel_x;
    logic signed [VALUE_W-1:0] prev_vel_y;
    logic [COUNT_W-1:0]        total_steps;
    logic [ALPHA_W-1:0]        blend_alpha;
    logic [FSTEPS_W-1:0]       frame_steps;
  } out_t;

  typedef struct packed {
    logic [STEP_W-1:0]         step_time;
    logic signed [VALUE_W-1:0] accel_x;
    logic signed [VALUE_W-1:0] accel_y;
    logic signed [DAMP_W-1:0]  damping;
    logic signed [VALUE_W-1:0] start_pos_x;
    logic signed [VALUE_W-1:0] start_pos_y;
    logic signed [VALUE_W-1:0] start_vel_x;
    logic signed [VALUE_W-1:0] start_vel_y;
  } cfg_t;

  // Request to the shared multiply-add unit: a * b >>> TIME_FRAC + addend.
  typedef struct packed {
    logic signed [VALUE_W-1:0] a;
    logic [MULB_W-1:0]         b;
    logic signed [VALUE_W-1:0] addend;
  } mac_req_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  acc;
    logic [STEP_W-1:0] dt;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [ALPHA_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- design/fsei_regs.sv -----
module fsei_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fsei_pkg::PADDR_W-1:0]  paddr,
  input  logic [fsei_pkg::PDATA_W-1:0]  pwdata,
  output logic [fsei_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output fsei_pkg::cfg_t                cfg_o
);

  fsei_pkg::cfg_t     cfg_q, cfg_d;
  fsei_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = fsei_pkg::reg_idx_e'(paddr[fsei_pkg::PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        fsei_pkg::REG_STEP_TIME:   cfg_d.step_time   = pwdata[fsei_pkg::STEP_W-1:0];
        fsei_pkg::REG_ACCEL_X:     cfg_d.accel_x     = pwdata;
        fsei_pkg::REG_ACCEL_Y:     cfg_d.accel_y     = pwdata;
        fsei_pkg::REG_DAMPING:     cfg_d.damping     = pwdata[fsei_pkg::DAMP_W-1:0];
        fsei_pkg::REG_START_POS_X: cfg_d.start_pos_x = pwdata;
        fsei_pkg::REG_START_POS_Y: cfg_d.start_pos_y = pwdata;
        fsei_pkg::REG_START_VEL_X: cfg_d.start_vel_x = pwdata;
        fsei_pkg::REG_START_VEL_Y: cfg_d.start_vel_y = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fsei_pkg::REG_STEP_TIME:   prdata = fsei_pkg::PDATA_W'(cfg_q.step_time);
      fsei_pkg::REG_ACCEL_X:     prdata = cfg_q.accel_x;
      fsei_pkg::REG_ACCEL_Y:     prdata = cfg_q.accel_y;
      fsei_pkg::REG_DAMPING:     prdata = fsei_pkg::PDATA_W'(cfg_q.damping);
      fsei_pkg::REG_START_POS_X: prdata = cfg_q.start_pos_x;
      fsei_pkg::REG_START_POS_Y: prdata = cfg_q.start_pos_y;
      fsei_pkg::REG_START_VEL_X: prdata = cfg_q.start_vel_x;
      fsei_pkg::REG_START_VEL_Y: prdata = cfg_q.start_vel_y;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{step_time: fsei_pkg::STEP_W'(1092),
                 damping:   fsei_pkg::DAMP_W'(65536),
                 default:   '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- design/fsei_mac.sv -----
module fsei_mac (
  input  logic                                clk_i,
  input  fsei_pkg::mac_req_t                  req_i,
  output logic signed [fsei_pkg::VALUE_W-1:0] result_o
);

  localparam int SHIFT_W = fsei_pkg::PROD_W - fsei_pkg::TIME_FRAC;
  localparam int SUM_W   = SHIFT_W + 1;
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - fsei_pkg::VALUE_W + 1){1'b0}}, {(fsei_pkg::VALUE_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO =
    {{(SUM_W - fsei_pkg::VALUE_W + 1){1'b1}}, {(fsei_pkg::VALUE_W - 1){1'b0}}};

  logic signed [fsei_pkg::PROD_W-1:0]  prod_d, prod_q;
  logic signed [fsei_pkg::VALUE_W-1:0] addend_q;
  logic signed [SHIFT_W-1:0]           shifted;
  logic signed [SUM_W-1:0]             sum;

  // b is never negative: zero-extend it into a signed operand.
  assign prod_d  = req_i.a * $signed({1'b0, req_i.b});
  // Drop the fraction bits, rounding toward minus infinity.
  assign shifted = prod_q[fsei_pkg::PROD_W-1:fsei_pkg::TIME_FRAC];
  assign sum     = SUM_W'(shifted) + SUM_W'(addend_q);

  always_comb begin
    if (sum > SAT_HI) begin
      result_o = SAT_HI[fsei_pkg::VALUE_W-1:0];
    end else if (sum < SAT_LO) begin
      result_o = SAT_LO[fsei_pkg::VALUE_W-1:0];
    end else begin
      result_o = sum[fsei_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    addend_q <= req_i.addend;
  end

endmodule

// ----- design/fsei_div.sv -----
module fsei_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fsei_pkg::div_req_t req_i,
  output fsei_pkg::div_rsp_t rsp_o
);

  localparam int REM_W = fsei_pkg::ACC_W + 1;
  localparam int CNT_W = $clog2(fsei_pkg::ALPHA_W + 1);

  logic                          busy_d, busy_q;
  logic                          done_d, done_q;
  logic [CNT_W-1:0]              cnt_d, cnt_q;
  logic [REM_W-1:0]              rem_d, rem_q, rem_sh, dt_ext;
  logic [fsei_pkg::ALPHA_W-1:0]  quot_d, quot_q;
  logic [fsei_pkg::STEP_W-1:0]   dt_d, dt_q;

  assign rem_sh = {rem_q[REM_W-2:0], 1'b0};
  assign dt_ext = REM_W'(dt_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dt_d   = dt_q;
    if (req_i.start) begin
      if (req_i.acc >= fsei_pkg::ACC_W'(req_i.dt)) begin
        // Quotient needs more than the fraction bits: saturate.
        quot_d = '1;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        rem_d  = REM_W'(req_i.acc);
        quot_d = '0;
        dt_d   = req_i.dt;
        cnt_d  = CNT_W'(fsei_pkg::ALPHA_W);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_sh >= dt_ext) begin
        rem_d  = rem_sh - dt_ext;
        quot_d = {quot_q[fsei_pkg::ALPHA_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[fsei_pkg::ALPHA_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dt_q   <= dt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- design/fixed_step_euler_integrator_top.sv -----
// Fixed-timestep accumulator with a semi-implicit Euler integrator for one 2-D body.
// An advance transaction clamps frame_time to a quarter second, adds it to the time
// accumulator (saturating at 65535) and then takes fixed steps while the accumulator
// holds at least step_time, at most 16385 per frame; a restart transaction reloads
// the start registers and clears the accumulator and step counter. Every input
// transaction yields exactly one output transaction with current and previous state,
// step counts and the blend alpha (leftover accumulator over step_time, Q0.16).
// Sequencing: one multiply-add unit serves every multiply-add of a step. Each step
// runs a check state, then six multiply-add operations, each an issue state and a
// write state (multiply, then add and saturate). After the last step a final check
// state starts the bit-serial alpha divider, which answers at once when alpha
// saturates and otherwise works one quotient bit at a time; then the output register
// is loaded. A restart goes from idle straight to loading the output register, and
// every load waits until the output register is free. The block takes no new
// transaction until the current one sits in the output register; that register may
// hold while the next frame is computed. Configuration must be written over the APB
// port only while the block is idle; the block itself does not enforce this.
module fixed_step_euler_integrator_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fsei_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fsei_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fsei_pkg::PADDR_W-1:0]  paddr,
  input  logic [fsei_pkg::PDATA_W-1:0]  pwdata,
  output logic [fsei_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_WRITE,
    ST_DIVIDE,
    ST_REPORT
  } state_e;

  // Operations of one axis within a step, in order.
  typedef enum logic [1:0] {
    OP_ACCEL,
    OP_DAMP,
    OP_POS
  } op_e;

  localparam int VW = fsei_pkg::VALUE_W;

  fsei_pkg::cfg_t     cfg;
  fsei_pkg::mac_req_t mac_req;
  fsei_pkg::div_req_t div_req;
  fsei_pkg::div_rsp_t div_rsp;
  logic signed [VW-1:0] mac_res;

  state_e state_d, state_q;
  op_e    op_d, op_q;
  logic   axis_d, axis_q;

  logic signed [VW-1:0] cur_pos_d [2];
  logic signed [VW-1:0] cur_pos_q [2];
  logic signed [VW-1:0] cur_vel_d [2];
  logic signed [VW-1:0] cur_vel_q [2];
  logic signed [VW-1:0] old_pos_d [2];
  logic signed [VW-1:0] old_pos_q [2];
  logic signed [VW-1:0] old_vel_d [2];
  logic signed [VW-1:0] old_vel_q [2];
  logic signed [VW-1:0] vtmp_d, vtmp_q;

  logic [fsei_pkg::ACC_W-1:0]    acc_d, acc_q;
  logic [fsei_pkg::COUNT_W-1:0]  total_d, total_q;
  logic [fsei_pkg::FSTEPS_W-1:0] fsteps_d, fsteps_q;
  logic [fsei_pkg::ALPHA_W-1:0]  alpha_d, alpha_q;
  fsei_pkg::out_t                out_d, out_q;
  logic                          out_valid_d, out_valid_q;

  logic [fsei_pkg::STEP_W-1:0]   dt_eff;
  logic [fsei_pkg::MULB_W-1:0]   damp_eff;
  logic [fsei_pkg::ACC_W-1:0]    ft_clamp;
  logic [fsei_pkg::ACC_W:0]      acc_sum;
  logic [fsei_pkg::ACC_W-1:0]    acc_add;
  logic                          can_step;
  logic                          in_accept;

  fsei_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fsei_mac u_mac (
    .clk_i    (clk_i),
    .req_i    (mac_req),
    .result_o (mac_res)
  );

  fsei_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // A zero step time behaves as the smallest step; negative damping stops motion.
  assign dt_eff   = (cfg.step_time == '0) ? fsei_pkg::STEP_W'(1) : cfg.step_time;
  assign damp_eff = cfg.damping[fsei_pkg::DAMP_W-1] ? '0
                                                     : cfg.damping[fsei_pkg::MULB_W-1:0];

  // Clamp the frame time and saturate the accumulator.
  assign ft_clamp = (in_data_i.frame_time > fsei_pkg::FRAME_CAP) ? fsei_pkg::FRAME_CAP
                                                                  : in_data_i.frame_time;
  assign acc_sum  = {1'b0, acc_q} + {1'b0, ft_clamp};
  assign acc_add  = acc_sum[fsei_pkg::ACC_W] ? '1 : acc_sum[fsei_pkg::ACC_W-1:0];

  assign can_step = (acc_q >= fsei_pkg::ACC_W'(dt_eff)) &&
                    (fsteps_q < fsei_pkg::MAX_FRAME_STEPS);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_accept   = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Operand selection for the shared multiply-add unit.
  always_comb begin
    case (op_q)
      OP_ACCEL: begin
        // velocity + dt * acceleration
        mac_req.a      = axis_q ? cfg.accel_y : cfg.accel_x;
        mac_req.b      = fsei_pkg::MULB_W'(dt_eff);
        mac_req.addend = cur_vel_q[axis_q];
      end
      OP_DAMP: begin
        // velocity * damping
        mac_req.a      = vtmp_q;
        mac_req.b      = damp_eff;
        mac_req.addend = '0;
      end
      OP_POS: begin
        // position + dt * new velocity
        mac_req.a      = vtmp_q;
        mac_req.b      = fsei_pkg::MULB_W'(dt_eff);
        mac_req.addend = cur_pos_q[axis_q];
      end
      default: begin
        mac_req.a      = '0;
        mac_req.b      = '0;
        mac_req.addend = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    axis_d      = axis_q;
    cur_pos_d   = cur_pos_q;
    cur_vel_d   = cur_vel_q;
    old_pos_d   = old_pos_q;
    old_vel_d   = old_vel_q;
    vtmp_d      = vtmp_q;
    acc_d       = acc_q;
    total_d     = total_q;
    fsteps_d    = fsteps_q;
    alpha_d     = alpha_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    div_req.start = 1'b0;
    div_req.acc   = acc_q;
    div_req.dt    = dt_eff;

    // Drop the result once the consumer takes it.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          fsteps_d = '0;
          alpha_d  = '0;
          if (in_data_i.cmd == fsei_pkg::CMD_RESTART) begin
            cur_pos_d[0] = cfg.start_pos_x;
            cur_pos_d[1] = cfg.start_pos_y;
            cur_vel_d[0] = cfg.start_vel_x;
            cur_vel_d[1] = cfg.start_vel_y;
            old_pos_d[0] = cfg.start_pos_x;
            old_pos_d[1] = cfg.start_pos_y;
            old_vel_d[0] = cfg.start_vel_x;
            old_vel_d[1] = cfg.start_vel_y;
            acc_d        = '0;
            total_d      = '0;
            state_d      = ST_REPORT;
          end else begin
            acc_d   = acc_add;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (can_step) begin
          // Save the state before this step.
          old_pos_d = cur_pos_q;
          old_vel_d = cur_vel_q;
          axis_d    = 1'b0;
          op_d      = OP_ACCEL;
          state_d   = ST_ISSUE;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIVIDE;
        end
      end
      ST_ISSUE: begin
        // Product is registered inside the unit this cycle.
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        state_d = ST_ISSUE;
        case (op_q)
          OP_ACCEL: begin
            vtmp_d = mac_res;
            op_d   = OP_DAMP;
          end
          OP_DAMP: begin
            vtmp_d            = mac_res;
            cur_vel_d[axis_q] = mac_res;
            op_d              = OP_POS;
          end
          OP_POS: begin
            cur_pos_d[axis_q] = mac_res;
            op_d              = OP_ACCEL;
            if (axis_q) begin
              // Both axes done: retire the step.
              acc_d    = acc_q - fsei_pkg::ACC_W'(dt_eff);
              total_d  = total_q + fsei_pkg::COUNT_W'(1);
              fsteps_d = fsteps_q + fsei_pkg::FSTEPS_W'(1);
              axis_d   = 1'b0;
              state_d  = ST_CHECK;
            end else begin
              axis_d = 1'b1;
            end
          end
          default: begin
            op_d    = OP_ACCEL;
            state_d = ST_CHECK;
          end
        endcase
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          alpha_d = div_rsp.quot;
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: begin
        // Load the output register as soon as it is free.
        if (!out_valid_q || out_ready_i) begin
          out_d.pos_x       = cur_pos_q[0];
          out_d.pos_y       = cur_pos_q[1];
          out_d.vel_x       = cur_vel_q[0];
          out_d.vel_y       = cur_vel_q[1];
          out_d.prev_pos_x  = old_pos_q[0];
          out_d.prev_pos_y  = old_pos_q[1];
          out_d.prev_vel_x  = old_vel_q[0];
          out_d.prev_vel_y  = old_vel_q[1];
          out_d.total_steps = total_q;
          out_d.blend_alpha = alpha_q;
          out_d.frame_steps = fsteps_q;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ACCEL;
      axis_q      <= 1'b0;
      cur_pos_q   <= '{default: '0};
      cur_vel_q   <= '{default: '0};
      old_pos_q   <= '{default: '0};
      old_vel_q   <= '{default: '0};
      acc_q       <= '0;
      total_q     <= '0;
      fsteps_q    <= '0;
      alpha_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      axis_q      <= axis_d;
      cur_pos_q   <= cur_pos_d;
      cur_vel_q   <= cur_vel_d;
      old_pos_q   <= old_pos_d;
      old_vel_q   <= old_vel_d;
      acc_q       <= acc_d;
      total_q     <= total_d;
      fsteps_q    <= fsteps_d;
      alpha_q     <= alpha_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vtmp_q <= vtmp_d;
    out_q  <= out_d;
  end

endmodule

// ----- design/fsei_chk.sv -----
`include "fixed_step_euler_integrator_top_macros.svh"

module fsei_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input fsei_pkg::out_t out_data_o,
  input logic           pready
);

  logic out_stall;
  logic steps_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign steps_ok  = !out_valid_o || (out_data_o.frame_steps <= fsei_pkg::MAX_FRAME_STEPS);

  // Busy in the cycle after taking a transaction.
  `FSEI_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A result waits until the consumer takes it.
  `FSEI_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o)

  // Hold the result payload while it waits.
  `FSEI_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_stall, $stable(out_data_o))

  // The register port never inserts wait states.
  `FSEI_ASSERT(a_pready_high, clk_i, rst_ni, pready)

  // Step limit per frame.
  `FSEI_ASSERT(a_frame_steps_cap, clk_i, rst_ni, steps_ok)

endmodule

bind fixed_step_euler_integrator_top fsei_chk u_fsei_chk (.*);

// ----- dv/fixed_step_euler_integrator_top_tb.sv -----
module fixed_step_euler_integrator_top_tb;
  import fsei_pkg::*;

  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  // Number of random frame transactions for each register setting.
  localparam int FRAMES_PER_SETTING = 105;

  // Clock, reset and the block's ports; every input starts at a known value.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  fixed_step_euler_integrator_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers and of the body state, advanced once per
  // accepted input transaction.
  cfg_t                live_cfg;
  logic signed [31:0]  pos_now[2];
  logic signed [31:0]  vel_now[2];
  logic signed [31:0]  pos_last[2];
  logic signed [31:0]  vel_last[2];
  longint              time_bank;
  logic [COUNT_W-1:0]  steps_total;

  // Expected output transactions, oldest first.
  out_t                pending_frames[$];

  // Idling knobs: percent chance per cycle, plus a long receiver hold-off.
  int unsigned         src_gap_pct = 0;
  int unsigned         sink_stall_pct = 0;
  int                  sink_hold_cycles = 0;

  int                  error_count = 0;
  int                  frames_checked = 0;
  int                  restarts_seen = 0;
  int                  capped_frames = 0;
  int                  alpha_saturations = 0;
  int                  settings_used = 0;

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------

  // Count and print every mismatch.
  task automatic flag_error(input string what);
    error_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("frame %0d %s: got %h, expected %h",
                           frames_checked, name, got, want));
  endtask

  task automatic compare_frame(input out_t got, input out_t want);
    check_field("pos_x", got.pos_x, want.pos_x);
    check_field("pos_y", got.pos_y, want.pos_y);
    check_field("vel_x", got.vel_x, want.vel_x);
    check_field("vel_y", got.vel_y, want.vel_y);
    check_field("prev_pos_x", got.prev_pos_x, want.prev_pos_x);
    check_field("prev_pos_y", got.prev_pos_y, want.prev_pos_y);
    check_field("prev_vel_x", got.prev_vel_x, want.prev_vel_x);
    check_field("prev_vel_y", got.prev_vel_y, want.prev_vel_y);
    check_field("total_steps", got.total_steps, want.total_steps);
    check_field("blend_alpha", 32'(got.blend_alpha), 32'(want.blend_alpha));
    check_field("frame_steps", 32'(got.frame_steps), 32'(want.frame_steps));
  endtask

  // Sample each output transaction at the rising edge and match it against
  // the oldest expectation.
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        flag_error("output transaction with no frame pending");
      end else begin
        want = pending_frames.pop_front();
        compare_frame(out_data_o, want);
        frames_checked++;
      end
    end
  end

  // Receiver: honor a long hold-off first, else stall at random.
  always @(negedge clk_i) begin
    if (sink_hold_cycles > 0) begin
      sink_hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] sat32(input longint x);
    if (x > VAL_MAX) return 32'sh7FFF_FFFF;
    if (x < VAL_MIN) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  // Apply one frame transaction to the shadow state and return the output
  // transaction it must produce.
  function automatic out_t integrate_frame(input in_t tr);
    out_t               res;
    longint             dt;
    longint             damp;
    longint             accel;
    longint             v;
    longint unsigned    alpha;
    int unsigned        taken;
    logic [FRAME_W-1:0] ft;
    int                 axis;
    // A zero step time behaves as the smallest step; negative damping as zero.
    dt = (live_cfg.step_time == '0) ? 64'sd1 : longint'(live_cfg.step_time);
    damp = (live_cfg.damping < 0) ? 64'sd0 : longint'(live_cfg.damping);
    taken = 0;
    alpha = 0;
    if (tr.cmd == CMD_RESTART) begin
      pos_now[0] = live_cfg.start_pos_x;
      pos_now[1] = live_cfg.start_pos_y;
      vel_now[0] = live_cfg.start_vel_x;
      vel_now[1] = live_cfg.start_vel_y;
      pos_last = pos_now;
      vel_last = vel_now;
      time_bank = 0;
      steps_total = '0;
      restarts_seen++;
    end else begin
      ft = (tr.frame_time > FRAME_CAP) ? FRAME_CAP : tr.frame_time;
      time_bank = time_bank + longint'(ft);
      if (time_bank > 65535) time_bank = 65535;
      while (time_bank >= dt && taken < 32'(MAX_FRAME_STEPS)) begin
        pos_last = pos_now;
        vel_last = vel_now;
        for (axis = 0; axis < 2; axis++) begin
          accel = (axis == 0) ? longint'(live_cfg.accel_x) : longint'(live_cfg.accel_y);
          // Semi-implicit Euler: velocity first, then position from the new velocity.
          v = longint'(sat32(longint'(vel_now[axis]) + ((dt * accel) >>> TIME_FRAC)));
          v = longint'(sat32((v * damp) >>> TIME_FRAC));
          vel_now[axis] = v[31:0];
          pos_now[axis] = sat32(longint'(pos_now[axis]) + ((dt * v) >>> TIME_FRAC));
        end
        time_bank -= dt;
        steps_total++;
        taken++;
      end
      alpha = (longint'(time_bank) << TIME_FRAC) / dt;
      if (alpha > 65535) begin
        alpha = 65535;
        alpha_saturations++;
      end
      if (taken == 32'(MAX_FRAME_STEPS)) capped_frames++;
    end
    res.pos_x       = pos_now[0];
    res.pos_y       = pos_now[1];
    res.vel_x       = vel_now[0];
    res.vel_y       = vel_now[1];
    res.prev_pos_x  = pos_last[0];
    res.prev_pos_y  = pos_last[1];
    res.prev_vel_x  = vel_last[0];
    res.prev_vel_y  = vel_last[1];
    res.total_steps = steps_total;
    res.blend_alpha = alpha[ALPHA_W-1:0];
    res.frame_steps = taken[FSTEPS_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one frame transaction; hold valid and payload until accepted, then
  // queue its expected output. Valid stays high until the next call or until
  // settle_frames drops it at the next falling edge.
  task automatic send_frame(input logic cmd, input logic [FRAME_W-1:0] ft);
    in_t tr;
    tr.cmd = cmd;
    tr.frame_time = ft;
    @(negedge clk_i);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tr;
    do @(posedge clk_i); while (!in_ready_o);
    pending_frames.push_back(integrate_frame(tr));
  endtask

  // Drop valid and wait until every expected output transaction has arrived.
  task automatic settle_frames();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle; mirror the register afterwards.
  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STEP_TIME:   live_cfg.step_time   = val[STEP_W-1:0];
      REG_ACCEL_X:     live_cfg.accel_x     = val;
      REG_ACCEL_Y:     live_cfg.accel_y     = val;
      REG_DAMPING:     live_cfg.damping     = val[DAMP_W-1:0];
      REG_START_POS_X: live_cfg.start_pos_x = val;
      REG_START_POS_Y: live_cfg.start_pos_y = val;
      REG_START_VEL_X: live_cfg.start_vel_x = val;
      REG_START_VEL_Y: live_cfg.start_vel_y = val;
      default: ;
    endcase
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    src_gap_pct = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Random value pickers
  // ---------------------------------------------------------------------------

  // Mostly moderate values so the body moves for a while, with full-range
  // and extreme values mixed in to drive the saturation paths.
  function automatic logic [31:0] pick_value(input int unsigned spread);
    case ($urandom_range(9))
      7:       return $urandom;
      8:       return 32'h7FFF_FFFF;
      9:       return 32'h8000_0000;
      default: return $urandom_range(2 * spread) - spread;
    endcase
  endfunction

  function automatic logic [31:0] pick_damping();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      6:       return {{14{r[17]}}, r[17:0]};
      7:       return 32'h0;
      8:       return 32'h0001_FFFF;
      9:       return 32'hFFFE_0000;
      default: return $urandom_range(66000, 58000);
    endcase
  endfunction

  // Keep step times large enough that a full frame stays at a few dozen steps.
  function automatic logic [31:0] pick_step_time();
    case ($urandom_range(7))
      0:       return 32'd1092;
      1:       return 32'd16384;
      2:       return 32'd32767;
      3:       return 32'd4000;
      default: return $urandom_range(32767, 300);
    endcase
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame_time();
    int unsigned dt;
    int unsigned top;
    dt = (live_cfg.step_time == '0) ? 1 : 32'(live_cfg.step_time);
    top = (3 * dt > 16384) ? 16384 : 3 * dt;
    case ($urandom_range(9))
      0, 1, 2, 3: return FRAME_W'($urandom_range(65535));
      4, 5, 6, 7: return FRAME_W'($urandom_range(top));
      8: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return FRAME_CAP;
          2:       return FRAME_CAP + FRAME_W'(1);
          default: return '1;
        endcase
      end
      default: return ($urandom_range(1) != 0) ? FRAME_W'(dt) : FRAME_W'(dt - 1);
    endcase
  endfunction

  task automatic write_random_settings();
    write_reg(REG_STEP_TIME, pick_step_time());
    write_reg(REG_ACCEL_X, pick_value(1310720));
    write_reg(REG_ACCEL_Y, pick_value(1310720));
    write_reg(REG_DAMPING, pick_damping());
    write_reg(REG_START_POS_X, pick_value(6553600));
    write_reg(REG_START_POS_Y, pick_value(6553600));
    write_reg(REG_START_VEL_X, pick_value(3276800));
    write_reg(REG_START_VEL_Y, pick_value(3276800));
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers and zero state: partial steps carried over, the quarter
  // second clamp, and a restart whose frame time must be ignored.
  task automatic test_reset_settings();
    send_frame(CMD_ADVANCE, 16'd0);
    send_frame(CMD_ADVANCE, 16'd1091);
    send_frame(CMD_ADVANCE, 16'd1);
    send_frame(CMD_ADVANCE, 16'hFFFF);
    send_frame(CMD_ADVANCE, FRAME_CAP + FRAME_W'(1));
    send_frame(CMD_RESTART, 16'hFFFF);
    send_frame(CMD_ADVANCE, FRAME_CAP);
    settle_frames();
  endtask

  // Extreme accelerations and start values so every sum saturates, maximum damping,
  // then negative damping that must act as zero, then full damping.
  task automatic test_saturating_motion();
    write_reg(REG_STEP_TIME, 32'd16384);
    write_reg(REG_ACCEL_X, 32'h7FFF_FFFF);
    write_reg(REG_ACCEL_Y, 32'h8000_0000);
    write_reg(REG_DAMPING, 32'h0001_FFFF);
    write_reg(REG_START_POS_X, 32'h7FFF_FFFF);
    write_reg(REG_START_POS_Y, 32'h8000_0000);
    write_reg(REG_START_VEL_X, 32'h7FFF_0000);
    write_reg(REG_START_VEL_Y, 32'h8000_0000);
    send_frame(CMD_RESTART, 16'd0);
    send_frame(CMD_ADVANCE, FRAME_CAP);
    send_frame(CMD_ADVANCE, 16'hFFFF);
    settle_frames();
    write_reg(REG_DAMPING, 32'hFFFE_0000);
    send_frame(CMD_RESTART, 16'd0);
    send_frame(CMD_ADVANCE, FRAME_CAP);
    settle_frames();
    write_reg(REG_ACCEL_X, 32'h8000_0000);
    write_reg(REG_ACCEL_Y, 32'h7FFF_FFFF);
    write_reg(REG_DAMPING, 32'h0001_0000);
    send_frame(CMD_RESTART, 16'd0);
    send_frame(CMD_ADVANCE, FRAME_CAP);
    settle_frames();
    settings_used += 3;
  endtask

  // Zero step time, then bank most of a long step, shrink the step to one
  // so the frame hits the per-frame step limit (alpha saturates), and show
  // the leftover carried into the next frame.
  task automatic test_step_limits();
    write_reg(REG_STEP_TIME, 32'd0);
    send_frame(CMD_RESTART, 16'd0);
    send_frame(CMD_ADVANCE, 16'd37);
    send_frame(CMD_ADVANCE, 16'd300);
    settle_frames();
    write_reg(REG_STEP_TIME, 32'd32767);
    send_frame(CMD_ADVANCE, FRAME_CAP);
    send_frame(CMD_ADVANCE, 16'd16382);
    settle_frames();
    write_reg(REG_STEP_TIME, 32'd1);
    send_frame(CMD_ADVANCE, FRAME_CAP);
    settle_frames();
    write_reg(REG_STEP_TIME, 32'd32767);
    send_frame(CMD_ADVANCE, 16'd0);
    send_frame(CMD_ADVANCE, 16'd2);
    settle_frames();
    settings_used += 3;
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the block fills and stalls its input; then pause the sender until
  // everything has drained before offering more.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    write_reg(REG_STEP_TIME, 32'd1092);
    write_reg(REG_DAMPING, 32'd64000);
    send_frame(CMD_RESTART, 16'd0);
    settle_frames();
    sink_hold_cycles = 600;
    repeat (8) send_frame(CMD_ADVANCE, pick_frame_time());
    settle_frames();
    repeat (5) send_frame(CMD_ADVANCE, pick_frame_time());
    settle_frames();
    settings_used++;
  endtask

  // Random register settings and frames under each idling pattern.
  task automatic test_random_traffic();
    int unsigned phase;
    logic        cmd;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(66, 0);
        2:       set_idling(0, 66);
        default: set_idling(11, 11);
      endcase
      repeat (3) begin
        settle_frames();
        write_random_settings();
        send_frame(CMD_RESTART, FRAME_W'($urandom_range(65535)));
        repeat (FRAMES_PER_SETTING) begin
          cmd = ($urandom_range(19) == 0) ? CMD_RESTART : CMD_ADVANCE;
          send_frame(cmd, (cmd == CMD_RESTART) ? FRAME_W'($urandom_range(65535))
                                               : pick_frame_time());
        end
      end
    end
    settle_frames();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : regression
    live_cfg = '0;
    live_cfg.step_time = STEP_W'(1092);
    live_cfg.damping = DAMP_W'(65536);
    pos_now = '{default: '0};
    vel_now = '{default: '0};
    pos_last = '{default: '0};
    vel_last = '{default: '0};
    time_bank = 0;
    steps_total = '0;

    // Hold reset at the start, then release it away from the rising edge.
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    test_reset_settings();
    test_saturating_motion();
    test_step_limits();
    test_output_backpressure();
    test_random_traffic();

    // Let any stray output transaction surface before the verdict.
    settle_frames();
    repeat (40) @(posedge clk_i);
    if (pending_frames.size() != 0)
      flag_error($sformatf("%0d frames never produced output", pending_frames.size()));

    $display("Checked %0d frame results over %0d register settings and 4 idling patterns.",
             frames_checked, settings_used);
    $display("Restarts: %0d, frames at the step limit: %0d, saturated alphas: %0d, errors: %0d.",
             restarts_seen, capped_frames, alpha_saturations, error_count);
    if (error_count == 0) begin
      $display("fixed_step_euler_integrator_top regression: pass");
    end else begin
      $display("fixed_step_euler_integrator_top regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, step-limit frames included.
  initial begin
    #200_000_000;
    $display("fixed_step_euler_integrator_top regression: fail");
    $finish;
  end

endmodule

// ----- fixed_step_euler_integrator_top.f -----
+incdir+design
design/fsei_pkg.sv
design/fsei_regs.sv
design/fsei_mac.sv
design/fsei_div.sv
design/fixed_step_euler_integrator_top.sv
design/fsei_chk.sv
dv/fixed_step_euler_integrator_top_tb.sv
